[src/trapezoid_pulse_generator_defines.svh]
// ---------------------------------------------------------------------------
// Trapezoid pulse generator assertion macros
// Clocked assertion helpers shared by the generator's RTL files.
// ---------------------------------------------------------------------------
`ifndef TRAPEZOID_PULSE_GENERATOR_DEFINES_SVH
`define TRAPEZOID_PULSE_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Check prop on every clock edge outside reset
`define TPG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tpg assertion failed");
// Check that expr never holds outside reset
`define TPG_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tpg forbidden condition");
`else
`define TPG_ASSERT(lbl, prop)
`define TPG_ASSERT_NEVER(lbl, expr)
`endif

`endif

[src/tpg_pkg.sv]
// ---------------------------------------------------------------------------
// Trapezoid pulse generator package
// Shared defaults, segment and register codes, queue status type.
// ---------------------------------------------------------------------------
package tpg_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int LEVEL_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int SEG_WIDTH       = 3;
  localparam int CFG_IDX_WIDTH   = 3;

  typedef enum logic [SEG_WIDTH-1:0] {
    SEG_DELAY   = 3'd0,
    SEG_RISE    = 3'd1,
    SEG_HIGH    = 3'd2,
    SEG_FALL    = 3'd3,
    SEG_LOW     = 3'd4
  } seg_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_DELAY   = 3'd0,
    CFG_RISE    = 3'd1,
    CFG_FALL    = 3'd2,
    CFG_WIDTH   = 3'd3,
    CFG_PERIOD  = 3'd4,
    CFG_LOW     = 3'd5,
    CFG_HIGH    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/tpg_if.sv]
// ---------------------------------------------------------------------------
// Trapezoid pulse generator channels
// Valid/ready stream interfaces for time words in and sample words out.
// ---------------------------------------------------------------------------
interface tpg_in_if #(
  parameter int TIME_WIDTH = tpg_pkg::TIME_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] time_tick;

  modport source (output valid, output time_tick, input ready);
  modport sink   (input valid, input time_tick, output ready);
endinterface

interface tpg_out_if #(
  parameter int LEVEL_WIDTH = tpg_pkg::LEVEL_WIDTH_DEF
);
  logic                               valid;
  logic                               ready;
  logic signed [LEVEL_WIDTH-1:0]      level;
  logic [tpg_pkg::SEG_WIDTH-1:0]      segment;

  modport source (output valid, output level, output segment, input ready);
  modport sink   (input valid, input level, input segment, output ready);
endinterface

[src/trapezoid_pulse_generator.sv]
// ---------------------------------------------------------------------------
// Trapezoid pulse generator
// Periodic trapezoidal pulse source evaluated at arbitrary tick times.
// ---------------------------------------------------------------------------
// The block takes one unsigned time word per clock on in_ch, unless its queue
// is full while its last stage holds a word, and returns the pulse level and
// its segment (delay, rising, high, falling, low) on out_ch, in order, one word
// per clock while out_ch is ready. The front end registers the delay subtract,
// reduces the time one period-reduction bit per stage and writes the queue;
// words pass from the two-entry queue into the ramp multiply, and the back end
// divides one quotient bit per stage into the output register. The front end
// keeps accepting while a result waits, until its queue fills.
// Ramp samples are truncated toward zero; a zero period gives a single pulse.
// Write the configuration registers only while nothing is in flight: the
// pipelines read them live.
// ---------------------------------------------------------------------------
module trapezoid_pulse_generator #(
  parameter int TIME_WIDTH  = tpg_pkg::TIME_WIDTH_DEF,
  parameter int LEVEL_WIDTH = tpg_pkg::LEVEL_WIDTH_DEF,
  parameter int CFG_WIDTH   = (TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tpg_in_if.sink                            in_ch,
  tpg_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [tpg_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]              cfg_data
);

  localparam int ENTRY_W = tpg_pkg::SEG_WIDTH + 2 * TIME_WIDTH;

  // Configuration registers
  logic [TIME_WIDTH-1:0]         delay_r, rise_r, fall_r, width_r, period_r;
  logic signed [LEVEL_WIDTH-1:0] low_r, high_r;

  // Queue between front and back ends
  logic                   push;
  logic                   pop;
  logic [ENTRY_W-1:0]     push_data;
  logic [ENTRY_W-1:0]     pop_data;
  tpg_pkg::q_stat_t       q_stat;

  // Latch register writes; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= '0;
      rise_r   <= TIME_WIDTH'(1);
      fall_r   <= TIME_WIDTH'(1);
      width_r  <= '0;
      period_r <= '0;
      low_r    <= '0;
      high_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpg_pkg::CFG_DELAY:  delay_r  <= cfg_data[TIME_WIDTH-1:0];
        tpg_pkg::CFG_RISE:   rise_r   <= cfg_data[TIME_WIDTH-1:0];
        tpg_pkg::CFG_FALL:   fall_r   <= cfg_data[TIME_WIDTH-1:0];
        tpg_pkg::CFG_WIDTH:  width_r  <= cfg_data[TIME_WIDTH-1:0];
        tpg_pkg::CFG_PERIOD: period_r <= cfg_data[TIME_WIDTH-1:0];
        tpg_pkg::CFG_LOW:    low_r    <= cfg_data[LEVEL_WIDTH-1:0];
        tpg_pkg::CFG_HIGH:   high_r   <= cfg_data[LEVEL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Front end: delay, period reduction, segment classification
  tpg_front #(
    .TIME_WIDTH (TIME_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .delay_ticks  (delay_r),
    .rise_ticks   (rise_r),
    .fall_ticks   (fall_r),
    .width_ticks  (width_r),
    .period_ticks (period_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  // Hold classified words until the back end can take them
  tpg_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // Back end: ramp scaling, division, output register
  tpg_back #(
    .TIME_WIDTH  (TIME_WIDTH),
    .LEVEL_WIDTH (LEVEL_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .low_level  (low_r),
    .high_level (high_r),
    .q_stat     (q_stat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[src/tpg_front.sv]
// ---------------------------------------------------------------------------
// Trapezoid pulse generator front end
// Subtract delay, reduce modulo period one bit per stage, classify segment.
// ---------------------------------------------------------------------------
`include "trapezoid_pulse_generator_defines.svh"

module tpg_front #(
  parameter int TIME_WIDTH = tpg_pkg::TIME_WIDTH_DEF,
  parameter int ENTRY_W    = tpg_pkg::SEG_WIDTH + 2 * TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tpg_in_if.sink                in_ch,
  input  logic [TIME_WIDTH-1:0] delay_ticks,
  input  logic [TIME_WIDTH-1:0] rise_ticks,
  input  logic [TIME_WIDTH-1:0] fall_ticks,
  input  logic [TIME_WIDTH-1:0] width_ticks,
  input  logic [TIME_WIDTH-1:0] period_ticks,
  input  tpg_pkg::q_stat_t      q_stat,
  output logic                  push,
  output logic [ENTRY_W-1:0]    push_data
);

  localparam int TW = TIME_WIDTH;

  logic [TW:0]   valid_r;
  logic [TW:0]   pre_r;
  logic [TW-1:0] mod_r   [TW+1];
  logic [TW-1:0] mod_nxt [TW+1];
  logic          en;
  logic          in_fire;

  logic [TW:0]     rw_sum;
  logic [TW+1:0]   rwf_sum;
  logic [TW-1:0]   s_last;
  tpg_pkg::seg_t   seg;
  logic [TW-1:0]   num;
  logic [TW-1:0]   den;

  // Stall only when the last stage holds a word the queue cannot take
  assign en          = !(valid_r[TW] && q_stat.full);
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;

  always_comb begin
    logic [2*TW-1:0] sh;
    logic [2*TW-1:0] cand;
    mod_nxt[0] = mod_r[0];
    for (int k = 0; k < TW; k++) begin
      sh   = {{TW{1'b0}}, period_ticks} << (TW - 1 - k);
      cand = {{TW{1'b0}}, mod_r[k]};
      if (period_ticks != '0 && cand >= sh) begin
        mod_nxt[k+1] = mod_r[k] - sh[TW-1:0];
      end else begin
        mod_nxt[k+1] = mod_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[TW-1:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mod_r[0] <= in_ch.time_tick - delay_ticks;
      pre_r    <= {pre_r[TW-1:0], in_ch.time_tick < delay_ticks};
      for (int k = 1; k <= TW; k++) begin
        mod_r[k] <= mod_nxt[k];
      end
    end
  end

  // Segment boundaries from the static configuration
  assign rw_sum  = {1'b0, rise_ticks} + {1'b0, width_ticks};
  assign rwf_sum = {1'b0, rw_sum} + {2'b0, fall_ticks};
  assign s_last  = mod_r[TW];

  always_comb begin
    num = s_last;
    den = rise_ticks;
    if (pre_r[TW]) begin
      seg = tpg_pkg::SEG_DELAY;
    end else if (s_last < rise_ticks) begin
      seg = tpg_pkg::SEG_RISE;
    end else if ({1'b0, s_last} < rw_sum) begin
      seg = tpg_pkg::SEG_HIGH;
    end else if ({2'b0, s_last} < rwf_sum) begin
      seg = tpg_pkg::SEG_FALL;
      num = s_last - rw_sum[TW-1:0];
      den = fall_ticks;
    end else begin
      seg = tpg_pkg::SEG_LOW;
    end
  end

  assign push      = valid_r[TW] && !q_stat.full;
  assign push_data = {seg, num, den};

  `TPG_ASSERT(a_accept_enters, in_fire |=> valid_r[0])
  `TPG_ASSERT(a_last_held, (valid_r[TW] && q_stat.full) |=> (valid_r[TW] && $stable(s_last)))

endmodule

[src/tpg_queue.sv]
// ---------------------------------------------------------------------------
// Trapezoid pulse generator queue
// Short FIFO that decouples the front end from the ramp back end.
// ---------------------------------------------------------------------------
`include "trapezoid_pulse_generator_defines.svh"

module tpg_queue #(
  parameter int ENTRY_W = 2 * tpg_pkg::TIME_WIDTH_DEF + tpg_pkg::SEG_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [ENTRY_W-1:0] push_data,
  input  logic               pop,
  output logic [ENTRY_W-1:0] pop_data,
  output tpg_pkg::q_stat_t   q_stat
);

  localparam int DEPTH = tpg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ENTRY_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `TPG_ASSERT_NEVER(a_count_range, count_r > CNT_W'(DEPTH))
  `TPG_ASSERT_NEVER(a_pop_empty, pop && q_stat.empty)

endmodule

[src/tpg_back.sv]
// ---------------------------------------------------------------------------
// Trapezoid pulse generator back end
// Scale the ramp step, divide one quotient bit per stage, truncate and drive out.
// ---------------------------------------------------------------------------
`include "trapezoid_pulse_generator_defines.svh"

module tpg_back #(
  parameter int TIME_WIDTH  = tpg_pkg::TIME_WIDTH_DEF,
  parameter int LEVEL_WIDTH = tpg_pkg::LEVEL_WIDTH_DEF,
  parameter int ENTRY_W     = tpg_pkg::SEG_WIDTH + 2 * TIME_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [LEVEL_WIDTH-1:0] low_level,
  input  logic signed [LEVEL_WIDTH-1:0] high_level,
  input  tpg_pkg::q_stat_t              q_stat,
  input  logic [ENTRY_W-1:0]            pop_data,
  output logic                          pop,
  tpg_out_if.source                     out_ch
);

  localparam int TW   = TIME_WIDTH;
  localparam int LW   = LEVEL_WIDTH;
  localparam int MW   = LW + 1;        // ramp step magnitude
  localparam int NDIV = MW;            // quotient bits
  localparam int PW   = MW + TW;       // product / remainder width

  logic                en;
  logic [NDIV:0]       valid_r;
  logic [PW-1:0]       rem_r  [NDIV+1];
  logic [PW-1:0]       rem_nxt[NDIV+1];
  logic [MW-1:0]       q_r    [NDIV+1];
  logic [MW-1:0]       q_nxt  [NDIV+1];
  logic [TW-1:0]       den_r  [NDIV+1];
  tpg_pkg::seg_t       seg_r  [NDIV+1];
  logic [NDIV:0]       neg_r;

  tpg_pkg::seg_t       in_seg;
  logic [TW-1:0]       in_num;
  logic [TW-1:0]       in_den;
  logic signed [MW-1:0] step;
  logic [MW-1:0]       mag;
  logic                neg;

  logic                out_valid_r;
  logic signed [LW-1:0] level_r, level_nxt;
  tpg_pkg::seg_t       segment_r;

  assign en  = !(out_valid_r && !out_ch.ready);
  assign pop = en && !q_stat.empty;

  assign in_seg = tpg_pkg::seg_t'(pop_data[ENTRY_W-1 -: tpg_pkg::SEG_WIDTH]);
  assign in_num = pop_data[2*TW-1:TW];
  assign in_den = pop_data[TW-1:0];

  // Signed step of the active ramp: high minus low for rise, low minus high for fall
  always_comb begin
    if (in_seg == tpg_pkg::SEG_FALL) begin
      step = MW'(low_level) - MW'(high_level);
    end else begin
      step = MW'(high_level) - MW'(low_level);
    end
    neg = step[MW-1];
    mag = neg ? MW'(-step) : MW'(step);
  end

  always_comb begin
    logic [PW-1:0] sh;
    rem_nxt[0] = rem_r[0];
    q_nxt[0]   = q_r[0];
    for (int j = 0; j < NDIV; j++) begin
      sh           = {{MW{1'b0}}, den_r[j]} << (NDIV - 1 - j);
      rem_nxt[j+1] = rem_r[j];
      q_nxt[j+1]   = q_r[j];
      if (rem_r[j] >= sh) begin
        rem_nxt[j+1]              = rem_r[j] - sh;
        q_nxt[j+1][NDIV - 1 - j]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NDIV-1:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= PW'(mag) * PW'(in_num);
      q_r[0]   <= '0;
      den_r[0] <= in_den;
      seg_r[0] <= in_seg;
      neg_r    <= {neg_r[NDIV-1:0], neg};
      for (int j = 1; j <= NDIV; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        den_r[j] <= den_r[j-1];
        seg_r[j] <= seg_r[j-1];
      end
    end
  end

  // Add the quotient to the ramp base, truncate toward zero
  always_comb begin
    logic signed [LW+1:0] base;
    logic signed [LW+1:0] qx;
    logic signed [LW+1:0] v;
    logic                 rnz;
    qx  = {1'b0, q_r[NDIV]};
    rnz = (rem_r[NDIV] != '0);
    if (seg_r[NDIV] == tpg_pkg::SEG_FALL) begin
      base = (LW+2)'(high_level);
    end else begin
      base = (LW+2)'(low_level);
    end
    if (neg_r[NDIV]) begin
      v = base - qx;
      if (rnz && v > 0) v = v - 1'b1;
    end else begin
      v = base + qx;
      if (rnz && v < 0) v = v + 1'b1;
    end
    case (seg_r[NDIV])
      tpg_pkg::SEG_RISE,
      tpg_pkg::SEG_FALL: level_nxt = v[LW-1:0];
      tpg_pkg::SEG_HIGH: level_nxt = high_level;
      default:           level_nxt = low_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_r[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level_r   <= level_nxt;
      segment_r <= seg_r[NDIV];
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.level   = level_r;
  assign out_ch.segment = segment_r;

  `TPG_ASSERT(a_out_hold, (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(level_r)))
  `TPG_ASSERT(a_high_level, (out_valid_r && segment_r == tpg_pkg::SEG_HIGH) |-> (level_r == high_level))

endmodule

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// Trapezoid pulse generator testbench
// Drives time words with random gaps through several register settings,
// predicts level and segment for each word and checks the sample stream.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = 32;
  localparam int LW = 16;
  localparam int FLUSH_CYCLES = 120;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic signed [LW-1:0] level;
    tpg_pkg::seg_t        segment;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  tpg_pkg::cfg_idx_t cfg_index = tpg_pkg::CFG_DELAY;
  logic [TW-1:0] cfg_data = '0;

  tpg_in_if #(.TIME_WIDTH(TW)) in_ch ();
  tpg_out_if #(.LEVEL_WIDTH(LW)) out_ch ();

  trapezoid_pulse_generator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the pulse registers
  logic [TW-1:0] delay_r, rise_r, fall_r, width_r, period_r;
  logic signed [LW-1:0] low_r, high_r;

  logic [TW-1:0] pending_times[$];
  sample_t       expected_samples[$];
  int mismatches = 0;
  longint cycles = 0;
  int hold_off = 0;
  bit in_gap_en = 1'b1;
  bit in_acc = 1'b0;
  bit out_acc = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Wait drawn before the next word: mostly zero, sometimes drawn from 0 to 17
  function automatic int draw_wait();
    return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 17)) : 0;
  endfunction

  // Truncate toward zero: base + d * num / den, num < den
  function automatic logic signed [LW-1:0] ramp_value(longint base, longint d,
                                                      longint unsigned num,
                                                      longint unsigned den);
    longint unsigned mag;
    longint unsigned prod;
    longint q;
    longint v;
    mag = d < 0 ? -d : d;
    prod = mag * num; // mag < 2^17, num < 2^32: fits
    q = longint'(prod / den);
    if (d < 0) begin
      v = base - q;
      if (prod % den != 0 && v > 0) v = v - 1;
    end else begin
      v = base + q;
      if (prod % den != 0 && v < 0) v = v + 1;
    end
    return LW'(v);
  endfunction

  function automatic sample_t pulse_sample(logic [TW-1:0] t);
    sample_t r;
    longint unsigned s;
    longint lo, hi;
    lo = low_r;
    hi = high_r;
    r.level = low_r;
    if (t < delay_r) begin
      r.segment = tpg_pkg::SEG_DELAY;
    end else begin
      s = t - delay_r;
      if (period_r != 0) s = s % period_r;
      if (s < rise_r) begin
        r.segment = tpg_pkg::SEG_RISE;
        r.level = ramp_value(lo, hi - lo, s, rise_r);
      end else if (s - rise_r < width_r) begin
        r.segment = tpg_pkg::SEG_HIGH;
        r.level = high_r;
      end else if (s - rise_r - width_r < fall_r) begin
        r.segment = tpg_pkg::SEG_FALL;
        r.level = ramp_value(hi, lo - hi, s - rise_r - width_r, fall_r);
      end else begin
        r.segment = tpg_pkg::SEG_LOW;
      end
    end
    return r;
  endfunction

  // Capture input handshakes at the edge that accepts them
  always @(posedge clk) begin
    in_acc <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Driver: present queued time words, drop valid for random gaps
  int in_wait = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.time_tick = '0;
  end
  always @(negedge clk) begin
    int gap;
    if (rst_n) begin
      if (in_acc) begin
        expected_samples.insert(expected_samples.size(), pulse_sample(in_ch.time_tick));
        void'(pending_times.pop_front());
        gap = in_gap_en ? draw_wait() : 0;
        if (gap == 0 && pending_times.size() > 0) begin
          in_ch.time_tick <= pending_times[0];
        end else begin
          in_ch.valid <= 1'b0;
          in_wait <= gap;
        end
      end else if (!in_ch.valid && pending_times.size() > 0) begin
        if (in_wait > 0) begin
          in_wait <= in_wait - 1;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.time_tick <= pending_times[0];
        end
      end
    end
  end

  // Receiver: random stall per word, plus a long hold-off on request
  int out_wait = 0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    int gap;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (out_acc && in_gap_en) begin
      gap = draw_wait();
      out_ch.ready <= (gap == 0);
      out_wait <= (gap == 0) ? 0 : gap - 1;
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: compare each accepted sample with the oldest expectation
  always @(posedge clk) begin
    sample_t exp_s;
    out_acc <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample level=%0d seg=%0d",
                                        out_ch.level, out_ch.segment);
      end else begin
        exp_s = expected_samples.pop_front();
        if (out_ch.level !== exp_s.level || out_ch.segment !== exp_s.segment) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: exp level=%0d seg=%0d got level=%0d seg=%0d",
                     exp_s.level, exp_s.segment, out_ch.level, out_ch.segment);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic write_reg(tpg_pkg::cfg_idx_t idx, logic [TW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      tpg_pkg::CFG_DELAY:  delay_r = value;
      tpg_pkg::CFG_RISE:   rise_r = value;
      tpg_pkg::CFG_FALL:   fall_r = value;
      tpg_pkg::CFG_WIDTH:  width_r = value;
      tpg_pkg::CFG_PERIOD: period_r = value;
      tpg_pkg::CFG_LOW:    low_r = value[LW-1:0];
      default:             high_r = value[LW-1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_pulse(logic [TW-1:0] dl, logic [TW-1:0] rs, logic [TW-1:0] wd,
                               logic [TW-1:0] fl, logic [TW-1:0] pr,
                               logic [LW-1:0] lo, logic [LW-1:0] hi);
    write_reg(tpg_pkg::CFG_DELAY, dl);
    write_reg(tpg_pkg::CFG_RISE, rs);
    write_reg(tpg_pkg::CFG_WIDTH, wd);
    write_reg(tpg_pkg::CFG_FALL, fl);
    write_reg(tpg_pkg::CFG_PERIOD, pr);
    write_reg(tpg_pkg::CFG_LOW, {{(TW-LW){1'b0}}, lo});
    write_reg(tpg_pkg::CFG_HIGH, {{(TW-LW){1'b0}}, hi});
  endtask

  // Wait until every word is through, then let the pipeline drain
  task automatic drain();
    while (pending_times.size() > 0 || expected_samples.size() > 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  // Random times mostly near the pulse, some anywhere
  task automatic queue_times(int n);
    longint unsigned span;
    span = longint'(delay_r) + rise_r + width_r + fall_r + 8;
    if (period_r != 0) span = span + 3 * longint'(period_r);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) pending_times.insert(pending_times.size(), $urandom());
      else pending_times.insert(pending_times.size(),
                                TW'(longint'(delay_r) + $urandom_range(0, 40)
                                    + ($urandom() % (span + 1)) - 4));
    end
  endtask

  initial begin
    delay_r = 0; rise_r = 1; fall_r = 1; width_r = 0; period_r = 0;
    low_r = 0; high_r = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: reset values, then segment edges and extremes
    pending_times = '{32'd0, 32'd1, 32'hFFFF_FFFF};
    drain();
    program_pulse(10, 4, 3, 5, 20, 16'h8000, 16'h7FFF);
    for (int t = 8; t <= 32; t++) pending_times.insert(pending_times.size(), TW'(t));
    drain();
    // Zero rise, width, fall; period shorter than the pulse
    program_pulse(0, 0, 0, 0, 0, 16'h7FFF, 16'h8000);
    pending_times = '{32'd0, 32'd5, 32'hFFFF_FFFF};
    drain();
    program_pulse(3, 10, 10, 10, 7, 16'hFF00, 16'h0100);
    for (int t = 0; t < 20; t++) pending_times.insert(pending_times.size(), TW'(t));
    drain();

    // Long stall at the receiver while words keep coming
    program_pulse(100, 1000, 500, 2000, 5000, 16'hC000, 16'h3FFF);
    in_gap_en = 1'b0;
    queue_times(80);
    hold_off = 300;
    drain();
    in_gap_en = 1'b1;

    // Random settings, including register extremes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_pulse(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 16'h8000, 16'h7FFF);
        1: program_pulse(0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 16'h7FFF, 16'h8000);
        default: program_pulse($urandom_range(0, 50), $urandom_range(0, 40),
                               $urandom_range(0, 30), $urandom_range(0, 40),
                               $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150),
                               LW'($urandom()), LW'($urandom()));
      endcase
      in_gap_en = (ph % 3) != 2;
      queue_times(40);
      if (ph == 0) pending_times.insert(pending_times.size(), 32'hFFFF_FFFE);
      drain();
    end

    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

[trapezoid_pulse_generator.f]
+incdir+src
src/tpg_pkg.sv
src/tpg_if.sv
src/tpg_front.sv
src/tpg_queue.sv
src/tpg_back.sv
src/trapezoid_pulse_generator.sv
test/tb_top.sv
